>>> sv/mmq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmq_pkg
// Shared types and constants of the message match queue.
// ----------------------------------------------------------------------------
package mmq_pkg;

    localparam int DEF_MAX_ENTRIES = 16;
    localparam int DEF_MAX_LENGTH  = 64;

    localparam int PID_W     = 7;
    localparam int OTHER_W   = 8;
    localparam int LEN_W     = 7;
    localparam int PAYLOAD_W = 32;
    localparam int STATUS_W  = 2;

    localparam logic [OTHER_W-1:0] ANY_PID = 8'hFF;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_LONG = 2'd2,
        ST_NONE = 2'd3
    } t_status;

    typedef struct packed {
        logic [OTHER_W-1:0]   target;
        logic [PID_W-1:0]     sender;
        logic [LEN_W-1:0]     len;
        logic [PAYLOAD_W-1:0] payload;
    } t_entry;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic                 exec;
        logic                 do_send;
        logic                 do_recv;
        logic [OTHER_W-1:0]   other;
        logic [PID_W-1:0]     pid;
        logic [LEN_W-1:0]     len;
        logic [PAYLOAD_W-1:0] payload;
    } t_cmd;

    // passed from one cell to the next, oldest first
    typedef struct packed {
        logic   seen;
        logic   prev_valid;
        t_entry sel;
    } t_link;

endpackage
`default_nettype wire

>>> sv/mmq_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmq_req_if / mmq_rsp_if
// Valid/ready channels for requests and results of the message match queue.
// ----------------------------------------------------------------------------
interface mmq_req_if;
    import mmq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [PID_W-1:0]           current_pid;
    logic signed [OTHER_W-1:0]  other_pid;
    logic [LEN_W-1:0]           length;
    logic [PAYLOAD_W-1:0]       payload;

    modport source (
        output valid, mode, current_pid, other_pid, length, payload,
        input  ready
    );
    modport sink (
        input  valid, mode, current_pid, other_pid, length, payload,
        output ready
    );
endinterface

interface mmq_rsp_if;
    import mmq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [PID_W-1:0]     sender_out;
    logic [LEN_W-1:0]     length_out;
    logic [PAYLOAD_W-1:0] payload_out;

    modport source (
        output valid, status, sender_out, length_out, payload_out,
        input  ready
    );
    modport sink (
        input  valid, status, sender_out, length_out, payload_out,
        output ready
    );
endinterface
`default_nettype wire

>>> sv/mmq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmq_cell
// One queue slot: holds an entry, matches it against a receive, appends on a
// send when it is the first free slot, and loads its right neighbor on removal.
// ----------------------------------------------------------------------------
module mmq_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire mmq_pkg::t_cmd   i_cmd,
    input  wire mmq_pkg::t_link  i_link,
    input  wire mmq_pkg::t_entry i_next_entry,
    input  wire logic            i_next_valid,
    output      mmq_pkg::t_link  o_link,
    output      mmq_pkg::t_entry o_entry,
    output      logic            o_valid
);
    import mmq_pkg::*;

    logic   r_valid;
    t_entry r_entry;
    logic   match;
    logic   take;
    logic   wr_en;
    logic   sh_en;
    logic [OTHER_W-1:0] me_ext;
    logic [OTHER_W-1:0] snd_ext;

    assign me_ext  = {1'b0, i_cmd.pid};
    assign snd_ext = {1'b0, r_entry.sender};

    assign match = r_valid &&
                   ((r_entry.target == me_ext && snd_ext == i_cmd.other) ||
                    (i_cmd.other == ANY_PID &&
                     (r_entry.target == ANY_PID || r_entry.target == me_ext)));
    assign take  = match && !i_link.seen;

    assign o_link.seen       = i_link.seen | match;
    assign o_link.prev_valid = r_valid;
    assign o_link.sel        = take ? r_entry : i_link.sel;

    assign wr_en = i_cmd.exec && i_cmd.do_send && !r_valid && i_link.prev_valid;
    assign sh_en = i_cmd.exec && i_cmd.do_recv && o_link.seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (wr_en) begin
            r_valid <= 1'b1;
        end else if (sh_en) begin
            r_valid <= i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_entry.target  <= i_cmd.other;
            r_entry.sender  <= i_cmd.pid;
            r_entry.len     <= i_cmd.len;
            r_entry.payload <= i_cmd.payload;
        end else if (sh_en) begin
            r_entry <= i_next_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_valid = r_valid;

endmodule
`default_nettype wire

>>> sv/message_match_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// message_match_queue
// Mailbox of pending messages in arrival order, built as a row of slot cells.
// ----------------------------------------------------------------------------
// A request is first captured; then, once the output register is free or
// being taken, every cell compares its entry at once, the first match ripples
// down the row of MAX_ENTRIES cells, and the matched cell and those behind it
// load from their right neighbor. The result sits in an output register until
// it is taken; the next request is accepted once the result is registered.
// Sends append to the first free cell; status 1 flags a bad length or a full
// queue, 2 a removed message too long for the receiver, 3 no matching message.
// ----------------------------------------------------------------------------
module message_match_queue #(
    parameter int MAX_ENTRIES = mmq_pkg::DEF_MAX_ENTRIES,
    parameter int MAX_LENGTH  = mmq_pkg::DEF_MAX_LENGTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mmq_req_if.sink   i_req,
    mmq_rsp_if.source o_rsp
);
    import mmq_pkg::*;

    localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_LENGTH);

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state                r_state;
    logic                  r_mode;
    logic [PID_W-1:0]      r_pid;
    logic [OTHER_W-1:0]    r_other;
    logic [LEN_W-1:0]      r_len;
    logic [PAYLOAD_W-1:0]  r_payload;
    logic                  r_out_valid;
    t_status               r_status;
    logic [PID_W-1:0]      r_sender_out;
    logic [LEN_W-1:0]      r_length_out;
    logic [PAYLOAD_W-1:0]  r_payload_out;

    t_cmd   cmd;
    t_link  link [0:MAX_ENTRIES];
    t_entry ent  [0:MAX_ENTRIES];
    logic   vld  [0:MAX_ENTRIES];
    logic   exec;
    logic   bad;
    logic   full;
    logic   hit;
    t_entry hit_ent;

    assign exec    = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);
    assign bad     = r_len > MaxLen;
    assign full    = link[MAX_ENTRIES].prev_valid;
    assign hit     = link[MAX_ENTRIES].seen;
    assign hit_ent = link[MAX_ENTRIES].sel;

    assign cmd.exec    = exec;
    assign cmd.do_send = !r_mode && !bad && !full;
    assign cmd.do_recv = r_mode && !bad;
    assign cmd.other   = r_other;
    assign cmd.pid     = r_pid;
    assign cmd.len     = r_len;
    assign cmd.payload = r_payload;

    assign link[0].seen       = 1'b0;
    assign link[0].prev_valid = 1'b1;
    assign link[0].sel        = '0;
    assign ent[MAX_ENTRIES]   = '0;
    assign vld[MAX_ENTRIES]   = 1'b0;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        mmq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_link       (link[g]),
            .i_next_entry (ent[g+1]),
            .i_next_valid (vld[g+1]),
            .o_link       (link[g+1]),
            .o_entry      (ent[g]),
            .o_valid      (vld[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (exec) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (exec) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.valid) begin
            r_mode    <= i_req.mode;
            r_pid     <= i_req.current_pid;
            r_other   <= i_req.other_pid;
            r_len     <= i_req.length;
            r_payload <= i_req.payload;
        end
        if (exec) begin
            r_sender_out  <= '0;
            r_length_out  <= '0;
            r_payload_out <= '0;
            if (bad || (!r_mode && full)) begin
                r_status <= ST_BAD;
            end else if (!r_mode) begin
                r_status <= ST_OK;
            end else if (!hit) begin
                r_status <= ST_NONE;
            end else if (hit_ent.len > r_len) begin
                r_status <= ST_LONG;
            end else begin
                r_status      <= ST_OK;
                r_sender_out  <= hit_ent.sender;
                r_length_out  <= hit_ent.len;
                r_payload_out <= hit_ent.payload;
            end
        end
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.sender_out  = r_sender_out;
    assign o_rsp.length_out  = r_length_out;
    assign o_rsp.payload_out = r_payload_out;

endmodule
`default_nettype wire
